// File: rtl/sprd_pkg.sv
// sprd_pkg: types, constants and the run-code decode function of the subtitle
// pixel-run decoder. Used by sprd_ctrl, sprd_dpath and the top level.
`default_nettype none

package sprd_pkg;

  // data type codes of a pixel-data sub-block
  localparam logic [7:0] TYPE_STR2  = 8'h10;
  localparam logic [7:0] TYPE_STR4  = 8'h11;
  localparam logic [7:0] TYPE_STR8  = 8'h12;
  localparam logic [7:0] TYPE_MAP24 = 8'h20;
  localparam logic [7:0] TYPE_MAP28 = 8'h21;
  localparam logic [7:0] TYPE_MAP48 = 8'h22;
  localparam logic [7:0] TYPE_EOL   = 8'hF0;

  localparam logic [4:0] MAP24_BYTES = 5'd2;
  localparam logic [4:0] MAP28_BYTES = 5'd4;
  localparam logic [4:0] MAP48_BYTES = 5'd16;

  localparam int unsigned BUF_W   = 31;
  localparam int unsigned WIN_W   = 24;
  localparam logic [4:0]  CNT_CAP = 5'd23;
  localparam logic [2:0]  MAX_TOK = 3'd4;

  typedef enum logic [2:0] {
    MODE_TYPE,
    MODE_STR2,
    MODE_STR4,
    MODE_STR8,
    MODE_TABLE
  } mode_e;

  typedef enum logic [2:0] {
    KIND_RUN = 3'd0,
    KIND_EOS = 3'd1,
    KIND_MAP = 3'd2,
    KIND_EOL = 3'd3,
    KIND_RSV = 3'd4
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_DECODE
  } state_e;

  typedef struct packed {
    logic       ok;
    logic       fin;
    logic [4:0] len;
    logic [7:0] code;
    logic [8:0] run;
  } tok_t;

  typedef struct packed {
    logic accept;
    logic take;
    logic push;
    logic push_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic to_string;
    logic tok_ok;
    logic hold_vld;
    logic hold_fin;
    logic hold_full;
  } stat_t;

  // decode one variable-length code from the top of the window; n is the
  // number of valid bits, ok stays low when the code is not complete yet
  function automatic tok_t decode_tok(input mode_e mode, input logic [WIN_W-1:0] w,
                                      input logic [4:0] n);
    tok_t t;
    t = '0;
    case (mode)
      MODE_STR2: begin
        if (n >= 5'd2) begin
          if (w[23:22] != 2'd0) begin
            t.ok = 1'b1; t.len = 5'd2; t.code = {6'd0, w[23:22]}; t.run = 9'd1;
          end else if (n >= 5'd3) begin
            if (w[21]) begin
              if (n >= 5'd8) begin
                t.ok = 1'b1; t.len = 5'd8; t.code = {6'd0, w[17:16]};
                t.run = {6'd0, w[20:18]} + 9'd3;
              end
            end else if (n >= 5'd4) begin
              if (w[20]) begin
                t.ok = 1'b1; t.len = 5'd4; t.run = 9'd1;
              end else if (n >= 5'd6) begin
                case (w[19:18])
                  2'd0: begin
                    t.ok = 1'b1; t.fin = 1'b1; t.len = 5'd6;
                  end
                  2'd1: begin
                    t.ok = 1'b1; t.len = 5'd6; t.run = 9'd2;
                  end
                  2'd2: begin
                    if (n >= 5'd12) begin
                      t.ok = 1'b1; t.len = 5'd12; t.code = {6'd0, w[13:12]};
                      t.run = {5'd0, w[17:14]} + 9'd12;
                    end
                  end
                  default: begin
                    if (n >= 5'd16) begin
                      t.ok = 1'b1; t.len = 5'd16; t.code = {6'd0, w[9:8]};
                      t.run = {1'b0, w[17:10]} + 9'd29;
                    end
                  end
                endcase
              end
            end
          end
        end
      end
      MODE_STR4: begin
        if (n >= 5'd4) begin
          if (w[23:20] != 4'd0) begin
            t.ok = 1'b1; t.len = 5'd4; t.code = {4'd0, w[23:20]}; t.run = 9'd1;
          end else if (n >= 5'd5) begin
            if (!w[19]) begin
              if (n >= 5'd8) begin
                t.ok = 1'b1; t.len = 5'd8;
                if (w[18:16] == 3'd0) t.fin = 1'b1;
                else t.run = {6'd0, w[18:16]} + 9'd2;
              end
            end else if (n >= 5'd6) begin
              if (!w[18]) begin
                if (n >= 5'd12) begin
                  t.ok = 1'b1; t.len = 5'd12; t.code = {4'd0, w[15:12]};
                  t.run = {7'd0, w[17:16]} + 9'd4;
                end
              end else if (n >= 5'd8) begin
                case (w[17:16])
                  2'd0: begin
                    t.ok = 1'b1; t.len = 5'd8; t.run = 9'd1;
                  end
                  2'd1: begin
                    t.ok = 1'b1; t.len = 5'd8; t.run = 9'd2;
                  end
                  2'd2: begin
                    if (n >= 5'd16) begin
                      t.ok = 1'b1; t.len = 5'd16; t.code = {4'd0, w[11:8]};
                      t.run = {5'd0, w[15:12]} + 9'd9;
                    end
                  end
                  default: begin
                    if (n >= 5'd20) begin
                      t.ok = 1'b1; t.len = 5'd20; t.code = {4'd0, w[7:4]};
                      t.run = {1'b0, w[15:8]} + 9'd25;
                    end
                  end
                endcase
              end
            end
          end
        end
      end
      MODE_STR8: begin
        if (n >= 5'd8) begin
          if (w[23:16] != 8'd0) begin
            t.ok = 1'b1; t.len = 5'd8; t.code = w[23:16]; t.run = 9'd1;
          end else if (n >= 5'd16) begin
            if (!w[15]) begin
              t.ok = 1'b1; t.len = 5'd16;
              if (w[14:8] == 7'd0) t.fin = 1'b1;
              else t.run = {2'd0, w[14:8]};
            end else if (n >= 5'd24) begin
              t.ok = 1'b1; t.len = 5'd24; t.code = w[7:0]; t.run = {2'd0, w[14:8]};
            end
          end
        end
      end
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/sprd_ctrl.sv
// sprd_ctrl: state machine of the subtitle pixel-run decoder. Sequences the
// byte handshake and the token decode loop. Depends on sprd_pkg.
`default_nettype none

module sprd_ctrl
  import sprd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (stat_i.to_string) state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!stat_i.hold_vld) begin
          // first token of the byte, or nothing complete yet
          if (stat_i.tok_ok) cmd_o.take = 1'b1;
          else state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.push      = 1'b1;
          cmd_o.push_last = stat_i.hold_fin || stat_i.hold_full || !stat_i.tok_ok;
          if (cmd_o.push_last) state_d = ST_IDLE;
          else cmd_o.take = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> stat_i.out_free)
    else $error("token pushed into a full output register");

  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !stat_i.hold_vld)
    else $error("held token left behind when returning to idle");

endmodule

`default_nettype wire

// File: rtl/sprd_dpath.sv
// sprd_dpath: datapath of the subtitle pixel-run decoder: bit buffer, parse
// mode, map table counters, held token and output register. Depends on sprd_pkg.
`default_nettype none

module sprd_dpath
  import sprd_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire  [7:0]  data_byte_i,
  input  wire         field_start_i,
  input  wire         out_ready_i,
  input  wire cmd_t   cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  output logic [2:0]  token_kind_o,
  output logic [7:0]  pixel_code_o,
  output logic [8:0]  run_length_o,
  output logic [3:0]  table_index_o,
  output logic        last_o
);

  mode_e             mode_q, mode_d;
  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [4:0]        tleft_q, tleft_d;
  logic [3:0]        tpos_q, tpos_d;
  logic [2:0]        ntok_q, ntok_d;
  logic              hold_vld_q, hold_vld_d;
  logic              hold_fin_q, hold_fin_d;
  logic [7:0]        hold_code_q, hold_code_d;
  logic [8:0]        hold_run_q, hold_run_d;
  logic              out_vld_q, out_vld_d;
  kind_e             out_kind_q, out_kind_d;
  logic [7:0]        out_code_q, out_code_d;
  logic [8:0]        out_run_q, out_run_d;
  logic [3:0]        out_idx_q, out_idx_d;
  logic              out_last_q, out_last_d;

  mode_e             eff_mode;
  logic [BUF_W-1:0]  aligned;
  logic [WIN_W-1:0]  win;
  tok_t              tok;
  logic              emit;
  kind_e             emit_kind;
  logic [4:0]        left_dec;
  logic [4:0]        cnt_base;
  logic              out_free;

  // oldest valid bit moves to the top of the window
  assign aligned  = buf_q << (5'd31 - cnt_q);
  assign win      = aligned[BUF_W-1 -: WIN_W];
  assign tok      = decode_tok(mode_q, win, cnt_q);
  assign eff_mode = field_start_i ? MODE_TYPE : mode_q;
  assign out_free = !out_vld_q || out_ready_i;
  assign left_dec = (tleft_q != 5'd0) ? tleft_q - 5'd1 : 5'd0;
  assign cnt_base = (cnt_q > CNT_CAP) ? CNT_CAP : cnt_q;

  always_comb begin
    stat_o.out_free  = out_free;
    stat_o.to_string = !field_start_i &&
                       (mode_q inside {MODE_STR2, MODE_STR4, MODE_STR8});
    stat_o.tok_ok    = tok.ok;
    stat_o.hold_vld  = hold_vld_q;
    stat_o.hold_fin  = hold_fin_q;
    stat_o.hold_full = (ntok_q == MAX_TOK);
  end

  always_comb begin
    mode_d      = mode_q;
    buf_d       = buf_q;
    cnt_d       = cnt_q;
    tleft_d     = tleft_q;
    tpos_d      = tpos_q;
    ntok_d      = ntok_q;
    hold_vld_d  = hold_vld_q;
    hold_fin_d  = hold_fin_q;
    hold_code_d = hold_code_q;
    hold_run_d  = hold_run_q;
    emit        = 1'b0;
    emit_kind   = KIND_RSV;

    if (cmd_i.accept) begin
      hold_vld_d = 1'b0;
      ntok_d     = 3'd0;
      case (eff_mode)
        MODE_TYPE: begin
          buf_d = '0;
          cnt_d = 5'd0;
          if (data_byte_i == TYPE_STR2) begin
            mode_d = MODE_STR2;
          end else if (data_byte_i == TYPE_STR4) begin
            mode_d = MODE_STR4;
          end else if (data_byte_i == TYPE_STR8) begin
            mode_d = MODE_STR8;
          end else if (data_byte_i inside {TYPE_MAP24, TYPE_MAP28, TYPE_MAP48}) begin
            mode_d  = MODE_TABLE;
            tpos_d  = 4'd0;
            tleft_d = (data_byte_i == TYPE_MAP24) ? MAP24_BYTES :
                      (data_byte_i == TYPE_MAP28) ? MAP28_BYTES : MAP48_BYTES;
          end else begin
            mode_d    = MODE_TYPE;
            emit      = 1'b1;
            emit_kind = (data_byte_i == TYPE_EOL) ? KIND_EOL : KIND_RSV;
          end
        end
        MODE_TABLE: begin
          emit      = 1'b1;
          emit_kind = KIND_MAP;
          tpos_d    = tpos_q + 4'd1;
          tleft_d   = left_dec;
          if (left_dec == 5'd0) begin
            mode_d = MODE_TYPE;
            tpos_d = 4'd0;
          end
        end
        default: begin
          buf_d = {buf_q[BUF_W-9:0], data_byte_i};
          cnt_d = cnt_base + 5'd8;
        end
      endcase
    end

    if (cmd_i.take) begin
      hold_vld_d  = 1'b1;
      hold_fin_d  = tok.fin;
      hold_code_d = tok.code;
      hold_run_d  = tok.run;
      cnt_d       = cnt_q - tok.len;
      ntok_d      = ntok_q + 3'd1;
    end else if (cmd_i.push) begin
      hold_vld_d = 1'b0;
    end

    // end of string: stuffing bits are dropped, next byte is a data type
    if (cmd_i.push && cmd_i.push_last && hold_fin_q) begin
      mode_d = MODE_TYPE;
      buf_d  = '0;
      cnt_d  = 5'd0;
    end
  end

  always_comb begin
    out_kind_d = out_kind_q;
    out_code_d = out_code_q;
    out_run_d  = out_run_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_kind_d = emit_kind;
      out_code_d = (emit_kind == KIND_MAP) ? data_byte_i : 8'd0;
      out_run_d  = 9'd0;
      out_idx_d  = (emit_kind == KIND_MAP) ? tpos_q : 4'd0;
      out_last_d = 1'b1;
    end else if (cmd_i.push) begin
      out_kind_d = hold_fin_q ? KIND_EOS : KIND_RUN;
      out_code_d = hold_code_q;
      out_run_d  = hold_run_q;
      out_idx_d  = 4'd0;
      out_last_d = cmd_i.push_last;
    end
    if (emit || cmd_i.push) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_TYPE;
      cnt_q      <= 5'd0;
      tleft_q    <= 5'd0;
      tpos_q     <= 4'd0;
      ntok_q     <= 3'd0;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      tleft_q    <= tleft_d;
      tpos_q     <= tpos_d;
      ntok_q     <= ntok_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q       <= buf_d;
    hold_fin_q  <= hold_fin_d;
    hold_code_q <= hold_code_d;
    hold_run_q  <= hold_run_d;
    out_kind_q  <= out_kind_d;
    out_code_q  <= out_code_d;
    out_run_q   <= out_run_d;
    out_idx_q   <= out_idx_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o   = out_vld_q;
  assign token_kind_o  = out_kind_q;
  assign pixel_code_o  = out_code_q;
  assign run_length_o  = out_run_q;
  assign table_index_o = out_idx_q;
  assign last_o        = out_last_q;

  a_hold_in_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q |-> (mode_q == MODE_STR2 || mode_q == MODE_STR4 || mode_q == MODE_STR8))
    else $error("held token outside a code string");

  a_tok_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ntok_q <= MAX_TOK)
    else $error("more than four tokens decoded from one byte");

endmodule

`default_nettype wire

// File: rtl/subtitle_pixel_run_decoder_top.sv
// subtitle_pixel_run_decoder_top: top level, joins sprd_ctrl and sprd_dpath.
// Depends on sprd_pkg.
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+--------------------------------------
//   in       | input     | in_valid_i / in_ready_o  | data_byte_i, field_start_i
//   out      | output    | out_valid_o / out_ready_i| token_kind_o, pixel_code_o,
//            |           |                          | run_length_o, table_index_o, last_o
//
// a map table byte, or a data type byte that opens no string or table, puts its token
// in the output register; a code string byte first loads the bit buffer, then its tokens
// go one at a time through the single run-code decoder, and a last step closes the byte
// the next byte is taken only once the output register is free or being drained
// a stalled output holds the decode loop; reset leaves the parser expecting a data type
`default_nettype none

module subtitle_pixel_run_decoder_top
  import sprd_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [7:0] data_byte_i,
  input  wire        field_start_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [2:0] token_kind_o,
  output logic [7:0] pixel_code_o,
  output logic [8:0] run_length_o,
  output logic [3:0] table_index_o,
  output logic       last_o
);

  cmd_t  cmd;
  stat_t stat;

  sprd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sprd_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .field_start_i (field_start_i),
    .out_ready_i   (out_ready_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .token_kind_o  (token_kind_o),
    .pixel_code_o  (pixel_code_o),
    .run_length_o  (run_length_o),
    .table_index_o (table_index_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire
